@@ rtl/vxd_pkg.sv @@
// Shared types and constants for the VXLAN decapsulator.
// Used by vxd_parser, vxd_fifo, vxd_output and vxlan_decapsulator_core.
`default_nettype none

package vxd_pkg;

    // Frame length limit and offset counter width (holds MAX_FRAME itself)
    localparam int MAX_FRAME = 65536;
    localparam int OFF_W     = $clog2(MAX_FRAME + 1);

    // Byte offsets inside the datagram
    localparam int OFF_FLAGS        = 0;
    localparam int OFF_VNI_FIRST    = 4;
    localparam int OFF_VNI_LAST     = 6;
    localparam int VXLAN_HDR_LEN    = 8;
    localparam int OFF_TYPE_HI      = 20;
    localparam int OFF_TYPE_LO      = 21;
    localparam int OFF_VLAN_TYPE_HI = 24;
    localparam int OFF_VLAN_TYPE_LO = 25;

    // VXLAN flag bit that marks a valid VNI
    localparam int VNI_FLAG_BIT = 3;

    // Ethernet type bytes
    localparam logic [7:0] ETH_IPV4_HI = 8'h08;
    localparam logic [7:0] ETH_IPV4_LO = 8'h00;
    localparam logic [7:0] ETH_IPV6_HI = 8'h86;
    localparam logic [7:0] ETH_IPV6_LO = 8'hdd;
    localparam logic [7:0] ETH_VLAN_HI = 8'h81;
    localparam logic [7:0] ETH_VLAN_LO = 8'h00;

    // Queue between parser and output stage
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_ACCEPT      = 3'd0,
        ST_SHORT_VXLAN = 3'd1,
        ST_SHORT_ETH   = 3'd2,
        ST_SHORT_VLAN  = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        V_UNDECIDED   = 2'd0,
        V_ACCEPT      = 2'd1,
        V_UNSUPPORTED = 2'd2
    } verdict_t;

    // One classified beat handed from the parser to the output stage
    typedef struct packed {
        logic [7:0]  data;
        logic        fwd;
        logic        first;
        logic        last;
        status_t     status;
        logic [23:0] vni;
    } rec_t;

    function automatic logic type_is_ip(input logic [7:0] hi, input logic [7:0] lo);
        type_is_ip = (hi == ETH_IPV4_HI && lo == ETH_IPV4_LO)
                  || (hi == ETH_IPV6_HI && lo == ETH_IPV6_LO);
    endfunction

endpackage

`default_nettype wire

@@ rtl/vxd_parser.sv @@
// Front part: walks the datagram one byte a cycle while in_take is high,
// collects the VNI and classifies the inner Ethernet type. Depends on vxd_pkg.
`default_nettype none

module vxd_parser
    import vxd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_take,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_last,
    output logic            rec_push,
    output rec_t            rec
);

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [23:0]      vni_reg, vni_next;
    logic [7:0]       type_hi_reg, type_hi_next;
    logic             vlan_reg, vlan_next;
    verdict_t         verdict_reg, verdict_next;
    logic             first_reg, first_next;

    logic             fwd;
    logic             first;
    status_t          status;
    logic [23:0]      vni_out;

    always_comb
    begin
        offset_next  = offset_reg;
        vni_next     = vni_reg;
        type_hi_next = type_hi_reg;
        vlan_next    = vlan_reg;
        verdict_next = verdict_reg;
        first_next   = first_reg;
        fwd          = 1'b0;
        first        = 1'b0;

        if (offset_reg < OFF_W'(MAX_FRAME))
        begin
            if (verdict_reg == V_ACCEPT)
            begin
                fwd        = 1'b1;
                first      = first_reg;
                first_next = 1'b0;
            end
            else if (offset_reg == OFF_W'(OFF_FLAGS))
            begin
                type_hi_next = data_byte;
            end
            else if (offset_reg >= OFF_W'(OFF_VNI_FIRST)
                  && offset_reg <= OFF_W'(OFF_VNI_LAST))
            begin
                if (type_hi_reg[VNI_FLAG_BIT])
                    vni_next = {vni_reg[15:0], data_byte};
            end
            else if (verdict_reg == V_UNDECIDED)
            begin
                if (offset_reg == OFF_W'(OFF_TYPE_HI)
                    || (offset_reg == OFF_W'(OFF_VLAN_TYPE_HI) && vlan_reg))
                begin
                    type_hi_next = data_byte;
                end
                else if (offset_reg == OFF_W'(OFF_TYPE_LO))
                begin
                    if (type_is_ip(type_hi_reg, data_byte))
                        verdict_next = V_ACCEPT;
                    else if (type_hi_reg == ETH_VLAN_HI && data_byte == ETH_VLAN_LO)
                        vlan_next = 1'b1;
                    else
                        verdict_next = V_UNSUPPORTED;
                end
                else if (offset_reg == OFF_W'(OFF_VLAN_TYPE_LO) && vlan_reg)
                begin
                    verdict_next = type_is_ip(type_hi_reg, data_byte)
                                 ? V_ACCEPT : V_UNSUPPORTED;
                end
            end
            offset_next = offset_reg + OFF_W'(1);
        end

        // End status from the state after this byte
        status  = ST_ACCEPT;
        vni_out = vni_next;
        if (frame_last)
        begin
            if (offset_next < OFF_W'(VXLAN_HDR_LEN))
            begin
                status  = ST_SHORT_VXLAN;
                vni_out = '0;
            end
            else if (verdict_next == V_ACCEPT)
                status = ST_ACCEPT;
            else if (verdict_next == V_UNSUPPORTED)
                status = ST_UNSUPPORTED;
            else
                status = vlan_next ? ST_SHORT_VLAN : ST_SHORT_ETH;
        end

        rec_push   = in_take && (fwd || frame_last);
        rec.data   = data_byte;
        rec.fwd    = fwd;
        rec.first  = first;
        rec.last   = frame_last;
        rec.status = status;
        rec.vni    = vni_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            vni_reg     <= '0;
            type_hi_reg <= '0;
            vlan_reg    <= 1'b0;
            verdict_reg <= V_UNDECIDED;
            first_reg   <= 1'b1;
        end
        else if (in_take)
        begin
            if (frame_last)
            begin
                // drop all per-frame state after the end beat
                offset_reg  <= '0;
                vni_reg     <= '0;
                type_hi_reg <= '0;
                vlan_reg    <= 1'b0;
                verdict_reg <= V_UNDECIDED;
                first_reg   <= 1'b1;
            end
            else
            begin
                offset_reg  <= offset_next;
                vni_reg     <= vni_next;
                type_hi_reg <= type_hi_next;
                vlan_reg    <= vlan_next;
                verdict_reg <= verdict_next;
                first_reg   <= first_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/vxd_fifo.sv @@
// Short queue of classified beats between parser and output stage.
// Depends on vxd_pkg for the record type and depth.
`default_nettype none

module vxd_fifo
    import vxd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  rec_t      wr_rec,
    output logic      fifo_full,
    input  wire logic rd_en,
    output logic      fifo_empty,
    output rec_t      rd_rec
);

    rec_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign fifo_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_rec     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/vxd_output.sv @@
// Back part: pulls classified beats from the queue into the output register
// and formats the result fields. Depends on vxd_pkg.
`default_nettype none

module vxd_output
    import vxd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fifo_empty,
    input  rec_t        fifo_rec,
    output logic        fifo_rd,
    input  wire logic   pop,
    output logic        empty,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic        payload_first,
    output logic [23:0] vni,
    output logic        frame_end,
    output logic [2:0]  frame_status
);

    logic out_valid_reg;
    rec_t out_reg;

    // Refill the output register when it is free or being taken this cycle
    assign fifo_rd = !fifo_empty && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fifo_rd)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_rd)
            out_reg <= fifo_rec;
    end

    assign payload_byte  = out_reg.fwd ? out_reg.data : 8'h00;
    assign payload_valid = out_reg.fwd;
    assign payload_first = out_reg.first;
    assign vni           = out_reg.vni;
    assign frame_end     = out_reg.last;
    assign frame_status  = out_reg.last ? out_reg.status : ST_ACCEPT;

endmodule

`default_nettype wire

@@ rtl/vxlan_decapsulator_core.sv @@
// VXLAN decapsulator top level: parser -> beat queue -> output register.
// Throughput: one datagram byte per cycle, sustained; full only rises when the consumer stalls.
// Result path: a result is written into a queue slot and then into the output register before it shows on the ports.
// Reset (rst_n, async, active low): clears parser state, empties queue and output register.
// Depends on vxd_pkg, vxd_parser, vxd_fifo, vxd_output.
`default_nettype none

module vxlan_decapsulator_core
    import vxd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // Input side: byte stream of the received datagram
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_last,

    // Result side: forwarded payload bytes and end-of-frame results
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            payload_first,
    output logic [23:0]     vni,
    output logic            frame_end,
    output logic [2:0]      frame_status
);

    logic in_take;
    logic rec_push;
    rec_t parse_rec;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_rd;
    rec_t head_rec;

    // The parser can only stall on the queue; an input beat is taken
    // whenever the queue has room for whatever result it may produce.
    assign full    = fifo_full;
    assign in_take = push && !fifo_full;

    // Front: walk header, collect VNI, classify inner type, mark payload beats
    vxd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .rec_push   (rec_push),
        .rec        (parse_rec)
    );

    // Decouple: hold classified beats while the consumer stalls
    vxd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (rec_push),
        .wr_rec     (parse_rec),
        .fifo_full  (fifo_full),
        .rd_en      (fifo_rd),
        .fifo_empty (fifo_empty),
        .rd_rec     (head_rec)
    );

    // Back: present the oldest result beat in a registered output stage
    vxd_output u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (fifo_empty),
        .fifo_rec      (head_rec),
        .fifo_rd       (fifo_rd),
        .pop           (pop),
        .empty         (empty),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .payload_first (payload_first),
        .vni           (vni),
        .frame_end     (frame_end),
        .frame_status  (frame_status)
    );

    // A shown result is either a forwarded byte or an end beat
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (payload_valid || frame_end))
        else $error("result beat with neither payload nor frame end");

    // Status other than accepted only on an end beat
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_end) |-> (frame_status == ST_ACCEPT))
        else $error("nonzero status on a non-end beat");

    // First flag only on a forwarded byte
    a_first_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && payload_first) |-> payload_valid)
        else $error("payload_first without payload_valid");

    // A short VXLAN header never reports a VNI and never forwards
    a_short_vxlan: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status == ST_SHORT_VXLAN) |-> (vni == 24'd0 && !payload_valid))
        else $error("short VXLAN end beat with VNI or payload");

    // A stalled output beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(payload_byte) && $stable(frame_end)))
        else $error("output beat changed while stalled");

endmodule

`default_nettype wire

@@ dv/tb_vxlan_decapsulator_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for vxlan_decapsulator_core: directed and random VXLAN datagrams.
// Depends on vxd_pkg and the vxlan_decapsulator_core RTL; needs no files or arguments.

module tb_vxlan_decapsulator_core;
    import vxd_pkg::*;

    // Cycles with no beat on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_BYTES = 380;
    localparam int DRAIN_CYCLES = 8;

    // One result beat as it appears on the output ports
    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        first;
        logic [23:0] vni;
        logic        frame_end;
        logic [2:0]  status;
    } payload_beat_t;

    // Inner Ethernet layouts the frame builder can produce; the IP kinds come first
    typedef enum int {
        INNER_IPV4,
        INNER_IPV6,
        INNER_VLAN_IPV4,
        INNER_VLAN_IPV6,
        INNER_VLAN_OTHER,
        INNER_OTHER
    } inner_kind_t;

    // Decap scoreboard: tracks per-frame parse state and queues the beats it implies
    class decap_scoreboard;
        logic [16:0]   offset;
        logic [23:0]   vni_acc;
        logic [7:0]    hi_byte;
        logic          vlan_tag;
        verdict_t      verdict;
        logic          first_due;
        payload_beat_t expected_beats[$];
        int            errors;
        int            bytes_in;
        int            beats_checked;

        function new();
            clear_frame();
        endfunction

        function void clear_frame();
            offset    = '0;
            vni_acc   = '0;
            hi_byte   = '0;
            vlan_tag  = 1'b0;
            verdict   = V_UNDECIDED;
            first_due = 1'b1;
        endfunction

        function bit carries_ip(logic [7:0] hi, logic [7:0] lo);
            return (hi == ETH_IPV4_HI && lo == ETH_IPV4_LO)
                || (hi == ETH_IPV6_HI && lo == ETH_IPV6_LO);
        endfunction

        // Advance the parse state by one accepted input byte
        function void note_byte(logic [7:0] b, logic is_last);
            bit            fwd;
            bit            first;
            payload_beat_t exp;
            fwd      = 1'b0;
            first    = 1'b0;
            bytes_in++;
            if (offset < MAX_FRAME)
            begin
                if (verdict == V_ACCEPT)
                begin
                    fwd       = 1'b1;
                    first     = first_due;
                    first_due = 1'b0;
                end
                else if (offset == OFF_FLAGS)
                begin
                    hi_byte = b;
                end
                else if (offset >= OFF_VNI_FIRST && offset <= OFF_VNI_LAST)
                begin
                    if (hi_byte[VNI_FLAG_BIT])
                        vni_acc = {vni_acc[15:0], b};
                end
                else if (verdict == V_UNDECIDED)
                begin
                    if (offset == OFF_TYPE_HI || (offset == OFF_VLAN_TYPE_HI && vlan_tag))
                    begin
                        hi_byte = b;
                    end
                    else if (offset == OFF_TYPE_LO)
                    begin
                        if (carries_ip(hi_byte, b))
                            verdict = V_ACCEPT;
                        else if (hi_byte == ETH_VLAN_HI && b == ETH_VLAN_LO)
                            vlan_tag = 1'b1;
                        else
                            verdict = V_UNSUPPORTED;
                    end
                    else if (offset == OFF_VLAN_TYPE_LO && vlan_tag)
                    begin
                        verdict = carries_ip(hi_byte, b) ? V_ACCEPT : V_UNSUPPORTED;
                    end
                end
                offset = offset + 1'b1;
            end
            if (!fwd && !is_last)
                return;
            exp.data      = fwd ? b : 8'h00;
            exp.valid     = fwd;
            exp.first     = first;
            exp.vni       = vni_acc;
            exp.frame_end = is_last;
            exp.status    = ST_ACCEPT;
            if (is_last)
            begin
                if (offset < VXLAN_HDR_LEN)
                begin
                    exp.status = ST_SHORT_VXLAN;
                    exp.vni    = '0;
                end
                else if (verdict == V_ACCEPT)
                begin
                    exp.status = ST_ACCEPT;
                end
                else if (verdict == V_UNSUPPORTED)
                begin
                    exp.status = ST_UNSUPPORTED;
                end
                else
                begin
                    exp.status = vlan_tag ? ST_SHORT_VLAN : ST_SHORT_ETH;
                end
            end
            expected_beats.push_back(exp);
            if (is_last)
                clear_frame();
        endfunction

        function void field_ok(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one popped result beat against the oldest expectation
        function void check_beat(payload_beat_t got);
            payload_beat_t exp;
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %p", $time, got);
                errors++;
                return;
            end
            exp = expected_beats.pop_front();
            field_ok("payload_byte",  24'(exp.data),      24'(got.data));
            field_ok("payload_valid", 24'(exp.valid),     24'(got.valid));
            field_ok("payload_first", 24'(exp.first),     24'(got.first));
            field_ok("vni",           exp.vni,            got.vni);
            field_ok("frame_end",     24'(exp.frame_end), 24'(got.frame_end));
            field_ok("frame_status",  24'(exp.status),    24'(got.status));
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        frame_last;
    logic        empty;
    logic        pop;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_first;
    logic [23:0] vni;
    logic        frame_end;
    logic [2:0]  frame_status;

    decap_scoreboard sb = new();

    logic [7:0] frame_bytes[$];
    int         frames_sent;
    int         push_burst;
    int         pop_burst;
    int         stall_cycles;

    vxlan_decapsulator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .frame_last    (frame_last),
        .empty         (empty),
        .pop           (pop),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .payload_first (payload_first),
        .vni           (vni),
        .frame_end     (frame_end),
        .frame_status  (frame_status)
    );

    always #2 clk = ~clk;

    // Draw a random idle gap, or none. Now and then start a burst of back-to-back
    // beats so the queue also sees stretches at full rate.
    function automatic int draw_gap(ref int burst_left);
        if (burst_left == 0 && $urandom_range(0, 15) == 0)
            burst_left = $urandom_range(8, 40);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Drive one byte: idle first, then hold push until a rising edge sees full low.
    // Returns at the falling edge after the beat, with push still high.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        bit taken;
        gap = draw_gap(push_burst);
        repeat (gap)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        data_byte  <= b;
        frame_last <= is_last;
        do
        begin
            @(posedge clk);
            taken = (full === 1'b0);
            if (taken)
                sb.note_byte(b, is_last);
            @(negedge clk);
        end
        while (!taken);
    endtask

    // Build a datagram: VXLAN header, inner MAC addresses, type (and tag), payload.
    // etype is only used by the two non-IP layouts.
    task automatic build_frame(input logic [7:0] flags, input logic [23:0] id,
                               input inner_kind_t kind, input logic [15:0] etype,
                               input int payload_len);
        frame_bytes.delete();
        frame_bytes.push_back(flags);
        repeat (3) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(id[23:16]);
        frame_bytes.push_back(id[15:8]);
        frame_bytes.push_back(id[7:0]);
        frame_bytes.push_back(8'($urandom));
        repeat (12) frame_bytes.push_back(8'($urandom));
        if (kind == INNER_VLAN_IPV4 || kind == INNER_VLAN_IPV6 || kind == INNER_VLAN_OTHER)
        begin
            frame_bytes.push_back(ETH_VLAN_HI);
            frame_bytes.push_back(ETH_VLAN_LO);
            repeat (2) frame_bytes.push_back(8'($urandom));
        end
        case (kind)
            INNER_IPV4, INNER_VLAN_IPV4:
            begin
                frame_bytes.push_back(ETH_IPV4_HI);
                frame_bytes.push_back(ETH_IPV4_LO);
            end
            INNER_IPV6, INNER_VLAN_IPV6:
            begin
                frame_bytes.push_back(ETH_IPV6_HI);
                frame_bytes.push_back(ETH_IPV6_LO);
            end
            default:
            begin
                frame_bytes.push_back(etype[15:8]);
                frame_bytes.push_back(etype[7:0]);
            end
        endcase
        repeat (payload_len) frame_bytes.push_back(8'($urandom));
    endtask

    // Send at most keep bytes of the built frame; mark the final one sent as last
    task automatic send_frame(input int keep);
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    // Result side: idle at random, hold pop until a beat comes, check it
    initial
    begin : result_side
        payload_beat_t got;
        int            gap;
        bit            taken;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(pop_burst);
            repeat (gap)
            begin
                pop <= 1'b0;
                @(negedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(posedge clk);
                taken = (empty === 1'b0);
                if (taken)
                begin
                    got = '{payload_byte, payload_valid, payload_first, vni,
                            frame_end, frame_status};
                    sb.check_beat(got);
                end
                @(negedge clk);
            end
            while (!taken);
        end
    end

    // Watchdog: count cycles with no beat on either side; a hang ends the run
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && full === 1'b0) || (pop && empty === 1'b0))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results still expected",
                         $time, STALL_LIMIT, sb.pending());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          start_bytes;
        int          pick;
        inner_kind_t kind;
        logic [7:0]  flags;
        push       = 1'b0;
        data_byte  = 8'h00;
        frame_last = 1'b0;
        rst_n      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: header truncation, both VNI flag states, field extremes
        build_frame(8'hff, 24'hffffff, INNER_IPV4, 16'h0000, 0);
        send_frame(1);
        build_frame(8'h00, 24'h000000, INNER_IPV4, 16'h0000, 0);
        send_frame(1);
        // Full VNI collected, but a short header reports VNI zero
        build_frame(8'h08, 24'h123456, INNER_IPV4, 16'h0000, 0);
        send_frame(7);
        // Full VXLAN header only: short Ethernet, VNI all ones
        build_frame(8'hff, 24'hffffff, INNER_IPV4, 16'h0000, 0);
        send_frame(8);
        // Type high byte seen, low byte missing
        build_frame(8'h08, 24'h654321, INNER_IPV4, 16'h0000, 0);
        send_frame(21);

        // Accepted layouts; flag clear with all other flag bits set gives VNI zero
        build_frame(8'h08, 24'habcdef, INNER_IPV4, 16'h0000, 5);
        send_frame(frame_bytes.size());
        build_frame(8'hf7, 24'h5a5a5a, INNER_IPV6, 16'h0000, 3);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h000001, INNER_VLAN_IPV4, 16'h0000, 4);
        send_frame(frame_bytes.size());
        // Empty payload, tagged and untagged: end beat only
        build_frame(8'h08, 24'h800000, INNER_VLAN_IPV6, 16'h0000, 0);
        send_frame(frame_bytes.size());
        build_frame(8'h0c, 24'h00ff00, INNER_IPV4, 16'h0000, 0);
        send_frame(frame_bytes.size());
        // One payload byte: first, forward and end in the same beat
        build_frame(8'h08, 24'h7e7e7e, INNER_IPV6, 16'h0000, 1);
        send_frame(frame_bytes.size());

        // Tag present but the inner type cut off
        build_frame(8'h08, 24'h111111, INNER_VLAN_IPV4, 16'h0000, 4);
        send_frame(23);
        // Unsupported types, including near misses and a double tag
        build_frame(8'h08, 24'h222222, INNER_VLAN_OTHER, 16'h0806, 6);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h333333, INNER_OTHER, 16'h0806, 6);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h444444, INNER_OTHER, 16'h0801, 2);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h555555, INNER_OTHER, 16'h86dc, 2);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h666666, INNER_OTHER, 16'h8101, 2);
        send_frame(frame_bytes.size());
        build_frame(8'h08, 24'h777777, INNER_VLAN_OTHER, 16'h8100, 2);
        send_frame(frame_bytes.size());

        // Random: mostly well-formed IP frames, some truncated or odd types, some noise
        start_bytes = sb.bytes_in;
        while (sb.bytes_in - start_bytes < RANDOM_BYTES)
        begin
            pick  = $urandom_range(0, 9);
            flags = 8'($urandom);
            flags[VNI_FLAG_BIT] = ($urandom_range(0, 4) != 0);
            if (pick <= 6)
            begin
                kind = inner_kind_t'($urandom_range(INNER_IPV4, INNER_VLAN_IPV6));
                build_frame(flags, 24'($urandom), kind, 16'($urandom),
                            $urandom_range(0, 16));
                send_frame(frame_bytes.size());
            end
            else if (pick <= 8)
            begin
                kind = inner_kind_t'($urandom_range(INNER_IPV4, INNER_OTHER));
                build_frame(flags, 24'($urandom), kind, 16'($urandom),
                            $urandom_range(0, 6));
                send_frame($urandom_range(1, frame_bytes.size()));
            end
            else
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
                send_frame(frame_bytes.size());
            end
        end
        push <= 1'b0;

        // Drain: wait for every expected beat, then idle for DRAIN_CYCLES to catch strays
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d datagrams (%0d bytes), checked %0d result beats;",
                 frames_sent, sb.bytes_in, sb.beats_checked);
        $display("covered short headers, tagged and untagged types, empty and one-byte payloads.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/vxd_pkg.sv
rtl/vxd_parser.sv
rtl/vxd_fifo.sv
rtl/vxd_output.sv
rtl/vxlan_decapsulator_core.sv
dv/tb_vxlan_decapsulator_core.sv
